// ===== rtl/isc_pkg.sv =====
// isc_pkg: shared types and codes for the imex stage complex update unit
// used by the top level and its port checker, no dependencies
`default_nettype none

package isc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DT_W    = 31;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned QUO_W   = 32;
  localparam int unsigned DEN_W   = 63;
  localparam int unsigned STAT_W  = 2;

  localparam logic signed [DATA_W-1:0] MAX_POS = 32'sh7fffffff;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZDIV = 2'd2
  } status_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_IMPL_ALPHA = 3'd1,
    CFG_IMPL_BETA  = 3'd2,
    CFG_EXPL_ALPHA = 3'd3,
    CFG_EXPL_BETA  = 3'd4
  } cfg_idx_e;

  // one quotient lane of the divider pipeline
  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  // what both lanes share while they divide
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             ov;
    logic             dz;
  } div_side_t;

endpackage

`default_nettype wire

// ===== rtl/imex_stage_complex_update_unit.sv =====
// imex_stage_complex_update_unit: pipelined imex runge-kutta stage update
// throughput one item per cycle unless stall_i holds the output; each stage loads when it is empty or drains
// the divide is restoring, one quotient bit per stage over 32 stages per lane
// reset clears the stage valid bits and the coefficient registers to zero
// depends on isc_pkg
`default_nettype none

module imex_stage_complex_update_unit #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [isc_pkg::CFG_W-1:0]           cfg_idx_i,
  input  wire logic [isc_pkg::DATA_W-1:0]          cfg_data_i,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   lin_re_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   lin_im_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   state_re_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   state_im_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   nl_new_re_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   nl_new_im_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   nl_old_re_i,
  input  wire logic signed [isc_pkg::DATA_W-1:0]   nl_old_im_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic signed [isc_pkg::DATA_W-1:0]        next_re_o,
  output logic signed [isc_pkg::DATA_W-1:0]        next_im_o,
  output logic [isc_pkg::STAT_W-1:0]               status_o
);
  import isc_pkg::*;

  localparam int unsigned SH   = 31 - FRAC_BITS;
  localparam int unsigned NST  = 11 + QUO_W;
  localparam int unsigned OUTS = NST - 1;
  // sum of two rounded 32 by 32 products
  localparam int unsigned EW   = 65 - FRAC_BITS;
  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic        [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [63:0] MAX64 = 64'sd2147483647;

  function automatic logic signed [63:0] rnd_q(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    r   = (mag + HALF) >> FRAC_BITS;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  // returns {clip, value}
  function automatic logic [32:0] sat_q(input logic signed [63:0] x);
    logic [32:0] res;
    if (x > MAX64) begin
      res = {1'b1, MAX_POS};
    end else if (x < -MAX64) begin
      res = {1'b1, -MAX_POS};
    end else begin
      res = {1'b0, x[31:0]};
    end
    return res;
  endfunction

  // coefficient registers
  logic [DT_W-1:0]          dt_q;
  logic signed [DATA_W-1:0] ia_q, ib_q, ea_q, eb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= '0;
      ia_q <= '0;
      ib_q <= '0;
      ea_q <= '0;
      eb_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:  dt_q <= cfg_data_i[DT_W-1:0];
        CFG_IMPL_ALPHA: ia_q <= cfg_data_i;
        CFG_IMPL_BETA:  ib_q <= cfg_data_i;
        CFG_EXPL_ALPHA: ea_q <= cfg_data_i;
        CFG_EXPL_BETA:  eb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and load enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  assign en[OUTS] = !v_q[OUTS] || !stall_i;
  for (genvar k = 0; k < OUTS; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[OUTS];

  // stage 1: dt times coefficient
  logic signed [63:0]       s1_mk_q [4];
  logic signed [DATA_W-1:0] s1_in_q [8];
  logic signed [DATA_W-1:0] dt_s;

  assign dt_s = $signed({1'b0, dt_q});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_mk_q[0] <= dt_s * ia_q;
      s1_mk_q[1] <= dt_s * ib_q;
      s1_mk_q[2] <= dt_s * ea_q;
      s1_mk_q[3] <= dt_s * eb_q;
      s1_in_q[0] <= lin_re_i;
      s1_in_q[1] <= lin_im_i;
      s1_in_q[2] <= state_re_i;
      s1_in_q[3] <= state_im_i;
      s1_in_q[4] <= nl_new_re_i;
      s1_in_q[5] <= nl_new_im_i;
      s1_in_q[6] <= nl_old_re_i;
      s1_in_q[7] <= nl_old_im_i;
    end
  end

  // stage 2: round and clip the scaled coefficients (kai, kbi, kae, kbe)
  logic signed [DATA_W-1:0] s2_k_q [4];
  logic signed [DATA_W-1:0] s2_in_q [8];
  logic                     s2_ov_q;
  logic [32:0]              s2_sat [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s2_sat[i] = sat_q(rnd_q(s1_mk_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        s2_k_q[i] <= s2_sat[i][31:0];
      end
      s2_in_q <= s1_in_q;
      s2_ov_q <= s2_sat[0][32] | s2_sat[1][32] | s2_sat[2][32] | s2_sat[3][32];
    end
  end

  // stage 3: coefficient times operator and nonlinear terms
  logic signed [63:0]       s3_p_q [8];
  logic signed [DATA_W-1:0] s3_v_q [2];
  logic                     s3_ov_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_p_q[0] <= s2_k_q[1] * s2_in_q[0];
      s3_p_q[1] <= s2_k_q[1] * s2_in_q[1];
      s3_p_q[2] <= s2_k_q[0] * s2_in_q[0];
      s3_p_q[3] <= s2_k_q[0] * s2_in_q[1];
      s3_p_q[4] <= s2_k_q[2] * s2_in_q[4];
      s3_p_q[5] <= s2_k_q[3] * s2_in_q[6];
      s3_p_q[6] <= s2_k_q[2] * s2_in_q[5];
      s3_p_q[7] <= s2_k_q[3] * s2_in_q[7];
      s3_v_q[0] <= s2_in_q[2];
      s3_v_q[1] <= s2_in_q[3];
      s3_ov_q   <= s2_ov_q;
    end
  end

  // stage 4: A, B and the summed explicit terms
  logic signed [DATA_W-1:0] s4_ab_q [4];
  logic signed [EW-1:0]     s4_e_q [2];
  logic signed [DATA_W-1:0] s4_v_q [2];
  logic                     s4_ov_q;
  logic [32:0]              s4_sat [4];
  logic signed [63:0]       s4_e [2];

  always_comb begin
    s4_sat[0] = sat_q(ONE - rnd_q(s3_p_q[0]));
    s4_sat[1] = sat_q(-rnd_q(s3_p_q[1]));
    s4_sat[2] = sat_q(ONE + rnd_q(s3_p_q[2]));
    s4_sat[3] = sat_q(rnd_q(s3_p_q[3]));
    s4_e[0]   = rnd_q(s3_p_q[4]) + rnd_q(s3_p_q[5]);
    s4_e[1]   = rnd_q(s3_p_q[6]) + rnd_q(s3_p_q[7]);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        s4_ab_q[i] <= s4_sat[i][31:0];
      end
      s4_e_q[0] <= s4_e[0][EW-1:0];
      s4_e_q[1] <= s4_e[1][EW-1:0];
      s4_v_q    <= s3_v_q;
      s4_ov_q   <= s3_ov_q | s4_sat[0][32] | s4_sat[1][32] | s4_sat[2][32]
                 | s4_sat[3][32];
    end
  end

  // stage 5: A times v
  logic signed [63:0]       s5_q_q [4];
  logic signed [DATA_W-1:0] s5_b_q [2];
  logic signed [EW-1:0]     s5_e_q [2];
  logic                     s5_ov_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_q_q[0] <= s4_ab_q[0] * s4_v_q[0];
      s5_q_q[1] <= s4_ab_q[1] * s4_v_q[1];
      s5_q_q[2] <= s4_ab_q[0] * s4_v_q[1];
      s5_q_q[3] <= s4_ab_q[1] * s4_v_q[0];
      s5_b_q[0] <= s4_ab_q[2];
      s5_b_q[1] <= s4_ab_q[3];
      s5_e_q    <= s4_e_q;
      s5_ov_q   <= s4_ov_q;
    end
  end

  // stage 6: right-hand side
  logic signed [DATA_W-1:0] s6_r_q [2];
  logic signed [DATA_W-1:0] s6_b_q [2];
  logic                     s6_ov_q;
  logic [32:0]              s6_av [2];
  logic [32:0]              s6_rs [2];
  logic signed [63:0]       s6_avx [2];
  logic signed [63:0]       s6_ex [2];

  always_comb begin
    s6_av[0]  = sat_q(rnd_q(s5_q_q[0]) - rnd_q(s5_q_q[1]));
    s6_av[1]  = sat_q(rnd_q(s5_q_q[2]) + rnd_q(s5_q_q[3]));
    for (int i = 0; i < 2; i++) begin
      s6_avx[i] = $signed(s6_av[i][31:0]);
      s6_ex[i]  = s5_e_q[i];
      s6_rs[i]  = sat_q(s6_avx[i] - s6_ex[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_r_q[0] <= s6_rs[0][31:0];
      s6_r_q[1] <= s6_rs[1][31:0];
      s6_b_q    <= s5_b_q;
      s6_ov_q   <= s5_ov_q | s6_av[0][32] | s6_av[1][32] | s6_rs[0][32] | s6_rs[1][32];
    end
  end

  // stage 7: products for |B|^2 and r times conj(B)
  logic signed [63:0] s7_p_q [6];
  logic               s7_ov_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_p_q[0] <= s6_b_q[0] * s6_b_q[0];
      s7_p_q[1] <= s6_b_q[1] * s6_b_q[1];
      s7_p_q[2] <= s6_r_q[0] * s6_b_q[0];
      s7_p_q[3] <= s6_r_q[1] * s6_b_q[1];
      s7_p_q[4] <= s6_r_q[1] * s6_b_q[0];
      s7_p_q[5] <= s6_r_q[0] * s6_b_q[1];
      s7_ov_q   <= s6_ov_q;
    end
  end

  // stage 8: divisor and numerators
  logic [DEN_W-1:0]   s8_den_q;
  logic signed [63:0] s8_num_q [2];
  logic               s8_ov_q;
  logic signed [63:0] s8_den;

  assign s8_den = s7_p_q[0] + s7_p_q[1];

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_den_q    <= s8_den[DEN_W-1:0];
      s8_num_q[0] <= s7_p_q[2] + s7_p_q[3];
      s8_num_q[1] <= s7_p_q[4] - s7_p_q[5];
      s8_ov_q     <= s7_ov_q;
    end
  end

  // stage 9: sign and magnitude of the numerators
  logic [DEN_W-1:0] s9_mag_q [2];
  logic             s9_neg_q [2];
  div_side_t        s9_side_q;
  logic signed [63:0] s9_abs [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s9_abs[i] = s8_num_q[i][63] ? -s8_num_q[i] : s8_num_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      for (int i = 0; i < 2; i++) begin
        s9_mag_q[i] <= s9_abs[i][DEN_W-1:0];
        s9_neg_q[i] <= s8_num_q[i][63];
      end
      s9_side_q.den <= s8_den_q;
      s9_side_q.ov  <= s8_ov_q;
      s9_side_q.dz  <= (s8_den_q == '0);
    end
  end

  // stage 10: integer part check and divider setup
  // quotient fits when the magnitude is below den shifted up by SH
  div_lane_t dl_q [QUO_W+1][2];
  div_side_t ds_q [QUO_W+1];
  logic [DEN_W+SH-1:0] s10_lim;
  div_lane_t           s10_lane [2];

  assign s10_lim = {s9_side_q.den, {SH{1'b0}}};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s10_lane[i].rem = s9_mag_q[i] >> SH;
      s10_lane[i].quo = {s9_mag_q[i][SH-1:0], {(FRAC_BITS+1){1'b0}}};
      s10_lane[i].neg = s9_neg_q[i];
      s10_lane[i].ovf = ({{SH{1'b0}}, s9_mag_q[i]} >= s10_lim);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      dl_q[0][0] <= s10_lane[0];
      dl_q[0][1] <= s10_lane[1];
      ds_q[0]    <= s9_side_q;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    div_lane_t nx [2];
    logic [DEN_W:0] t [2];
    logic           ge [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l]      = {dl_q[j][l].rem, dl_q[j][l].quo[QUO_W-1]};
        ge[l]     = (t[l] >= {1'b0, ds_q[j].den});
        nx[l]     = dl_q[j][l];
        nx[l].rem = ge[l] ? DEN_W'(t[l] - {1'b0, ds_q[j].den}) : t[l][DEN_W-1:0];
        nx[l].quo = {dl_q[j][l].quo[QUO_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[10+j]) begin
        dl_q[j+1][0] <= nx[0];
        dl_q[j+1][1] <= nx[1];
        ds_q[j+1]    <= ds_q[j];
      end
    end
  end

  // output stage: round quotient, clip, apply sign, zero a zero-divisor result, set status
  logic [QUO_W:0]           fin_r [2];
  logic [QUO_W-1:0]         fin_q [2];
  logic                     fin_clip [2];
  logic [DATA_W-1:0]        fin_mag [2];
  logic signed [DATA_W-1:0] fin_val [2];
  logic                     fin_ov;
  status_e                  fin_st;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_r[l]    = {1'b0, dl_q[QUO_W][l].quo} + (QUO_W+1)'(1);
      fin_q[l]    = fin_r[l][QUO_W:1];
      fin_clip[l] = fin_q[l][QUO_W-1] | dl_q[QUO_W][l].ovf;
      fin_mag[l]  = fin_clip[l] ? MAX_POS : fin_q[l];
      fin_val[l]  = dl_q[QUO_W][l].neg ? -$signed(fin_mag[l]) : $signed(fin_mag[l]);
    end
    fin_ov = ds_q[QUO_W].ov | fin_clip[0] | fin_clip[1];
    if (ds_q[QUO_W].dz) begin
      fin_st = ST_ZDIV;
    end else if (fin_ov) begin
      fin_st = ST_SAT;
    end else begin
      fin_st = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) begin
      next_re_o <= ds_q[QUO_W].dz ? '0 : fin_val[0];
      next_im_o <= ds_q[QUO_W].dz ? '0 : fin_val[1];
      status_o  <= fin_st;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/isc_checker.sv =====
// isc_checker: port-level checks for the imex stage complex update unit
// depends on isc_pkg; bound to imex_stage_complex_update_unit below
`default_nettype none

module isc_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               valid_o,
  input wire logic                               stall_i,
  input wire logic signed [isc_pkg::DATA_W-1:0]  next_re_o,
  input wire logic signed [isc_pkg::DATA_W-1:0]  next_im_o,
  input wire logic [isc_pkg::STAT_W-1:0]         status_o
);
  import isc_pkg::*;

  // a zero divisor always yields a zero result
  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == ST_ZDIV |-> next_re_o == '0 && next_im_o == '0)
    else $error("zero divisor item with nonzero result");

  // saturation is symmetric, the most negative code never shows
  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> next_re_o != -MAX_POS - 1 && next_im_o != -MAX_POS - 1)
    else $error("result outside symmetric range");

  // a full-scale result never carries the zero divisor code
  a_clip_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (next_re_o == MAX_POS || next_re_o == -MAX_POS) |->
      status_o == ST_SAT || status_o == ST_OK)
    else $error("full-scale result with zero divisor code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(next_re_o) && $stable(next_im_o)
      && $stable(status_o))
    else $error("stalled item changed");

endmodule

bind imex_stage_complex_update_unit isc_checker u_isc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .valid_o   (valid_o),
  .stall_i   (stall_i),
  .next_re_o (next_re_o),
  .next_im_o (next_im_o),
  .status_o  (status_o)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for imex_stage_complex_update_unit
// predicts each stage update in a scoreboard class, drives items and coefficients by tasks
// depends on isc_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top;
  import isc_pkg::*;

  localparam int FRAC = 24;
  localparam logic [CFG_W-1:0] CFG_UNUSED = 3'd7;
  localparam int LIMIT = 400000;
  localparam int TAIL = 60;
  localparam longint MAXQ = 64'sd2147483647;

  typedef logic signed [DATA_W-1:0] field_vec_t [8];

  typedef struct {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    status_e st;
  } update_t;

  class update_scoreboard;
    longint dt, ia, ib, ea, eb;
    update_t expected_q[$];
    int fails;
    int checked;

    function void report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endfunction

    function longint sat(longint x, inout bit ov);
      if (x > MAXQ) begin
        ov = 1;
        return MAXQ;
      end
      if (x < -MAXQ) begin
        ov = 1;
        return -MAXQ;
      end
      return x;
    endfunction

    // round to FRAC fraction bits, half away from zero
    function longint rnd(longint x);
      bit neg;
      longint unsigned mag, r;
      neg = x < 0;
      mag = neg ? longint'(-x) : x;
      r = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint qdiv(longint num, longint unsigned den, inout bit ov);
      bit neg, b;
      longint unsigned n, q, r;
      neg = num < 0;
      n = neg ? longint'(-num) : num;
      q = n / den;
      r = n % den;
      if (q > (64'd2147483647 >> FRAC)) begin
        ov = 1;
        return neg ? -MAXQ : MAXQ;
      end
      for (int i = 0; i <= FRAC; i++) begin
        b = r >= den - r;
        r = b ? r - (den - r) : r << 1;
        q = (q << 1) | longint'(b);
      end
      q = (q + 1) >> 1;
      if (q > 64'd2147483647) begin
        ov = 1;
        q = 64'd2147483647;
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void set_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        CFG_TIME_STEP:  dt = longint'({1'b0, d[DT_W-1:0]});
        CFG_IMPL_ALPHA: ia = longint'($signed(d));
        CFG_IMPL_BETA:  ib = longint'($signed(d));
        CFG_EXPL_ALPHA: ea = longint'($signed(d));
        CFG_EXPL_BETA:  eb = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function void note_input(field_vec_t f);
      bit ov;
      longint lr, li, vr, vi, n1r, n1i, n0r, n0i;
      longint kai, kbi, kae, kbe, ar, ai, br, bi, avr, avi, rr, ri, xr, xi;
      longint unsigned den;
      update_t u;
      ov = 0;
      lr = f[0]; li = f[1]; vr = f[2]; vi = f[3];
      n1r = f[4]; n1i = f[5]; n0r = f[6]; n0i = f[7];
      kai = sat(rnd(dt * ia), ov);
      kbi = sat(rnd(dt * ib), ov);
      kae = sat(rnd(dt * ea), ov);
      kbe = sat(rnd(dt * eb), ov);
      ar = sat((64'sd1 << FRAC) - rnd(kbi * lr), ov);
      ai = sat(-rnd(kbi * li), ov);
      br = sat((64'sd1 << FRAC) + rnd(kai * lr), ov);
      bi = sat(rnd(kai * li), ov);
      avr = sat(rnd(ar * vr) - rnd(ai * vi), ov);
      avi = sat(rnd(ar * vi) + rnd(ai * vr), ov);
      rr = sat(avr - rnd(kae * n1r) - rnd(kbe * n0r), ov);
      ri = sat(avi - rnd(kae * n1i) - rnd(kbe * n0i), ov);
      den = longint'(br * br) + longint'(bi * bi);
      if (den == 0) begin
        xr = 0;
        xi = 0;
        u.st = ST_ZDIV;
      end else begin
        xr = qdiv(rr * br + ri * bi, den, ov);
        xi = qdiv(ri * br - rr * bi, den, ov);
        u.st = ov ? ST_SAT : ST_OK;
      end
      u.re = xr[31:0];
      u.im = xi[31:0];
      expected_q.push_back(u);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] re, logic signed [DATA_W-1:0] im,
                               logic [STAT_W-1:0] st);
      update_t u;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected item re=%h im=%h st=%0d", re, im, st));
        return;
      end
      u = expected_q.pop_front();
      if (re !== u.re || im !== u.im || st !== u.st)
        report($sformatf("item %0d: got %h %h %0d, want %h %h %0d",
                         checked, re, im, st, u.re, u.im, u.st));
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic valid_i = 0;
  logic stall_o;
  logic signed [DATA_W-1:0] lin_re_i = 0, lin_im_i = 0, state_re_i = 0, state_im_i = 0;
  logic signed [DATA_W-1:0] nl_new_re_i = 0, nl_new_im_i = 0, nl_old_re_i = 0, nl_old_im_i = 0;
  logic valid_o;
  logic stall_i = 0;
  logic signed [DATA_W-1:0] next_re_o, next_im_o;
  logic [STAT_W-1:0] status_o;

  imex_stage_complex_update_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .valid_i, .stall_o,
    .lin_re_i, .lin_im_i, .state_re_i, .state_im_i,
    .nl_new_re_i, .nl_new_im_i, .nl_old_re_i, .nl_old_im_i,
    .valid_o, .stall_i, .next_re_o, .next_im_o, .status_o
  );

  update_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 0;
  logic hold_on = 0;
  int cycles = 0;
  int sent = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // long receiver hold-off so the pipeline fills and backs up its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1;
    repeat (400) @(posedge clk_i);
    hold_on <= 0;
  end

  always @(posedge clk_i) begin
    stall_i <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o)
      sb.note_input('{lin_re_i, lin_im_i, state_re_i, state_im_i,
                      nl_new_re_i, nl_new_im_i, nl_old_re_i, nl_old_im_i});
    if (rst_ni && valid_o && !stall_i)
      sb.check_result(next_re_o, next_im_o, status_o);
  end

  // called just after posedge clk_i
  task automatic write_reg(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, d);
  endtask

  task automatic load_coefs(logic [DATA_W-1:0] dt, logic [DATA_W-1:0] ia,
                            logic [DATA_W-1:0] ib, logic [DATA_W-1:0] ea,
                            logic [DATA_W-1:0] eb);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_IMPL_ALPHA, ia);
    write_reg(CFG_IMPL_BETA, ib);
    write_reg(CFG_EXPL_ALPHA, ea);
    write_reg(CFG_EXPL_BETA, eb);
  endtask

  task automatic send_item(field_vec_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 0;
      @(posedge clk_i);
    end
    valid_i <= 1;
    {lin_re_i, lin_im_i, state_re_i, state_im_i} <= {f[0], f[1], f[2], f[3]};
    {nl_new_re_i, nl_new_im_i, nl_old_re_i, nl_old_im_i} <= {f[4], f[5], f[6], f[7]};
    do @(posedge clk_i); while (stall_o);
    sent++;
  endtask

  task automatic drain();
    valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_field();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
      6, 7: return $urandom;
      8: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return int'($urandom_range(512)) - 256;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_coef();
    if ($urandom_range(7) == 0) return $urandom;
    return int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
  endfunction

  task automatic random_items(int n);
    field_vec_t f;
    for (int k = 0; k < n; k++) begin
      foreach (f[j]) f[j] = rand_field();
      send_item(f);
    end
  endtask

  localparam logic signed [DATA_W-1:0] ONE = 32'sh0100_0000;
  localparam logic signed [DATA_W-1:0] MINV = 32'sh8000_0000;

  initial begin
    field_vec_t f;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset coefficients: plain copy of the state through a unit divisor
    send_item('{ONE, ONE, ONE, -ONE, 0, 0, 0, 0});
    send_item('{MAX_POS, MINV, MAX_POS, MINV, MAX_POS, MINV, MAX_POS, MINV});
    drain();

    // dt = aI = 1 makes B zero when L = -1; stray bits and indexes must be ignored
    load_coefs(ONE | 32'h8000_0000, ONE, ONE, ONE, -ONE);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    send_item('{-ONE, 0, ONE, ONE, ONE, ONE, ONE, ONE});
    send_item('{-ONE, 0, MAX_POS, MINV, MAX_POS, MINV, 0, 0});
    send_item('{0, 0, 0, 0, 0, 0, 0, 0});
    send_item('{MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS});
    send_item('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
    send_item('{ONE, ONE, ONE, 0, 0, 0, 0, 0});
    send_item('{-ONE, ONE, ONE, ONE, 0, 0, 0, 0});
    send_item('{ONE >>> 8, -ONE, MAX_POS, 0, 32'sh7f, -32'sh7f, 1, -1});
    // tiny divisor: large quotient saturates
    send_item('{-(ONE - 1), 0, ONE, ONE, 0, 0, 0, 0});
    drain();

    // extreme coefficients: intermediate clipping everywhere
    load_coefs(32'h7fff_ffff, MINV, MAX_POS, MINV, MAX_POS);
    for (int k = 0; k < 6; k++) begin
      foreach (f[j]) f[j] = rand_field();
      send_item(f);
    end
    send_item('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
    drain();

    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (p % 4 == 0) begin
        case (p / 4)
          0: load_coefs(ONE >> 4, rand_coef(), rand_coef(), rand_coef(), rand_coef());
          1: load_coefs($urandom_range(32'h0200_0000), rand_coef(), rand_coef(),
                        rand_coef(), rand_coef());
          2: load_coefs(0, MAX_POS, MINV, MAX_POS, MINV);
          default: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
      end
      if (p == 4) hold_go = 1;
      random_items(48);
      if (p % 4 == 3) drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    $display("sent %0d items over seven coefficient settings, checked %0d results", sent,
             sb.checked);
    $display("covered zero divisor, saturation, extremes, backpressure and idle gaps");
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
